[rtl/tccw_pkg.sv]
// Shared types and constants for the text console cell writer.
// Holds field widths, item kind codes, register indexes and the cell layout.
// No dependencies; imported by the top level.
package tccw_pkg;

  localparam int KIND_W      = 3;
  localparam int CHAR_W      = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int CLR_W       = 4;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int ECOL_W      = 8;
  localparam int EROW_W      = 7;
  localparam int BLINK_W     = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BLINK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SETCUR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK    = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] COLS_RST = 7'd80;
  localparam logic [CFG_W-1:0] ROWS_RST = 7'd25;
  localparam logic [CLR_W-1:0] FORE_RST = 4'd15;
  localparam logic [CLR_W-1:0] BACK_RST = 4'd0;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

  typedef struct packed {
    logic              dirty;
    logic [CLR_W-1:0]  back;
    logic [CLR_W-1:0]  fore;
    logic [CHAR_W-1:0] ch;
  } cell_t;

  localparam cell_t RESET_CELL = '{dirty: 1'b1, back: BACK_RST, fore: FORE_RST,
                                   ch: BLANK_CODE};

endpackage

[rtl/tccw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module tccw_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 5120
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tccw_mac.sv]
// Shared multiply-add unit: res = a * b + c, registered.
// Standalone; used by the top level for cell addresses and area sizes.
module tccw_mac #(
  parameter int A_W = 7,
  parameter int B_W = 8,
  parameter int C_W = 8,
  parameter int R_W = 13
) (
  input  logic           clk,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [C_W-1:0] c,
  output logic [R_W-1:0] res
);

  localparam int P_W = ((A_W + B_W > C_W) ? A_W + B_W : C_W) + 1;

  logic [P_W-1:0] full;
  logic [R_W-1:0] res_r;

  assign full = P_W'(a) * P_W'(b) + P_W'(c);

  always_ff @(posedge clk) begin
    res_r <= R_W'(full);
  end

  assign res = res_r;

endmodule

[rtl/text_console_cell_writer_unit.sv]
// Text console cell writer, top level. Uses tccw_pkg, tccw_ram and tccw_mac.
// Blink, set cursor, out-of-range reads and unknown kinds go from decode to the output
// register; an in-range read adds address, read issue and read data, a printable
// character address and write, a newline address and write for each padded cell; a
// scroll or a clear adds a sweep over the used area. One transaction at a time;
// in_tready returns once the result is loaded. Reset (rst_n low, synchronous) clears
// control state, then blanks all MAX_COLUMNS*MAX_ROWS cells while in_tready is low.
module text_console_cell_writer_unit #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 64,
  parameter int BLINK_TICKS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] char_code, [14:8] pos_x, [20:15] pos_y, upper bits zero
  input  logic [tccw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] kind
  input  logic [tccw_pkg::KIND_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [6:0] cur_col, [12:7] cur_row, [13] cursor_visible, [14] redraw_request,
  // [15] scrolled, [23:16] read_char, [27:24] read_fore, [31:28] read_back,
  // [32] read_dirty, upper bits zero
  output logic [tccw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]         cfg_data
);
  import tccw_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((CNT_W > ECOL_W) ? CNT_W : ECOL_W) + 1;

  // Sequencer states.
  localparam logic [3:0] ST_INIT   = 4'd0;   // clearing pass after reset
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DISP   = 4'd2;   // decode the transaction
  localparam logic [3:0] ST_ADDR   = 4'd3;   // cell address through the multiply-add
  localparam logic [3:0] ST_WR     = 4'd4;   // write character cell, advance cursor
  localparam logic [3:0] ST_RDI    = 4'd5;   // issue cell read
  localparam logic [3:0] ST_RDD    = 4'd6;   // take read data, clear dirty mark
  localparam logic [3:0] ST_SM1    = 4'd7;   // moved-cell count
  localparam logic [3:0] ST_SM2    = 4'd8;   // total-cell count
  localparam logic [3:0] ST_SPRIME = 4'd9;   // first source read of the sweep
  localparam logic [3:0] ST_SMOVE  = 4'd10;  // one cell per cycle
  localparam logic [3:0] ST_FIN    = 4'd11;  // load the output register

  // Control state.
  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic [CNT_W-1:0]   i_r;
  logic [CFG_W-1:0]   cols_used_r;
  logic [CFG_W-1:0]   rows_used_r;
  logic [CLR_W-1:0]   fore_r;
  logic [CLR_W-1:0]   back_r;
  logic [COL_W-1:0]   cursor_col_r;
  logic [ROW_W-1:0]   cursor_row_r;
  logic [BLINK_W-1:0] blink_cnt_r;
  logic               blink_on_r;
  logic               out_valid_r;

  // Transaction payload and working registers.
  logic [KIND_W-1:0]      kind_r;
  logic [CHAR_W-1:0]      char_r;
  logic [COL_W-1:0]       px_r;
  logic [ROW_W-1:0]       py_r;
  logic                   redraw_r;
  logic                   sc_r;
  logic                   clear_r;
  cell_t                  rd_cell_r;
  logic [AW-1:0]          addr_r;
  logic [CNT_W-1:0]       lim_r;
  logic [CNT_W-1:0]       tot_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Store and multiply-add connections.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  cell_t         ram_rdata;
  logic [EROW_W-1:0] mac_a;
  logic [ECOL_W-1:0] mac_c;
  logic [CNT_W-1:0]  mac_res;

  // Derived values.
  logic [ECOL_W-1:0] eff_cols;
  logic [EROW_W-1:0] eff_rows;
  logic [ECOL_W-1:0] new_cols;
  logic [EROW_W-1:0] new_rows;
  logic [EROW_W-1:0] rows_m1;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic [ECOL_W-1:0] col_inc;
  logic [EROW_W-1:0] row_inc;
  logic              wrap;
  logic              scroll_hit;
  logic              is_nl;
  logic              rd_in_range;
  logic [BLINK_W-1:0] blink_dec;
  logic [CNT_W-1:0]  tot_last;
  logic              move_last;
  logic              init_last;
  logic [SUM_W-1:0]  src_next;
  logic [SUM_W-1:0]  src_first;
  logic              in_fire;
  logic              fin_load;
  cell_t             blank_cell;

  // The used area: zero means one, anything above the maximum means the maximum.
  function automatic logic [ECOL_W-1:0] eff_cols_f(input logic [CFG_W-1:0] v);
    logic [ECOL_W-1:0] w;
    w = ECOL_W'(v);
    if (w == '0) return ECOL_W'(1);
    if (w > ECOL_W'(MAX_COLUMNS)) return ECOL_W'(MAX_COLUMNS);
    return w;
  endfunction

  function automatic logic [EROW_W-1:0] eff_rows_f(input logic [CFG_W-1:0] v);
    logic [EROW_W-1:0] w;
    w = EROW_W'(v);
    if (w == '0) return EROW_W'(1);
    if (w > EROW_W'(MAX_ROWS)) return EROW_W'(MAX_ROWS);
    return w;
  endfunction

  assign eff_cols = eff_cols_f(cols_used_r);
  assign eff_rows = eff_rows_f(rows_used_r);
  assign new_cols = eff_cols_f(cfg_data);
  assign new_rows = eff_rows_f(cfg_data);
  assign rows_m1  = eff_rows - EROW_W'(1);
  assign last_col = COL_W'(eff_cols - ECOL_W'(1));
  assign last_row = ROW_W'(rows_m1);

  // Cursor advance after a cell write; a wrap past the last used row scrolls.
  assign col_inc    = ECOL_W'(cursor_col_r) + ECOL_W'(1);
  assign row_inc    = EROW_W'(cursor_row_r) + EROW_W'(1);
  assign wrap       = (col_inc >= eff_cols);
  assign scroll_hit = wrap && (row_inc >= eff_rows);

  assign is_nl       = (char_r == NEWLINE_CODE);
  assign rd_in_range = (ECOL_W'(px_r) < eff_cols) && (EROW_W'(py_r) < eff_rows);
  assign blink_dec   = blink_cnt_r - BLINK_W'(1);

  assign tot_last  = tot_r - CNT_W'(1);
  assign move_last = (i_r == tot_last);
  assign init_last = (i_r == CNT_W'(DEPTH - 1));

  // During the sweep the source cell sits one row below the cell being written,
  // and it is read in the cycle before its write to cover the registered read.
  assign src_next  = SUM_W'(i_r) + SUM_W'(1) + SUM_W'(eff_cols);
  assign src_first = SUM_W'(eff_cols);

  assign in_fire  = in_tvalid && in_tready;
  assign fin_load = !out_valid_r || out_tready;

  always_comb begin
    blank_cell.dirty = 1'b1;
    blank_cell.back  = back_r;
    blank_cell.fore  = fore_r;
    blank_cell.ch    = BLANK_CODE;
  end

  // Next state, store port and multiply-add operand selection.
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = i_r[AW-1:0];
    ram_wdata = blank_cell;
    ram_raddr = addr_r;
    mac_a     = '0;
    mac_c     = '0;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        if (init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        case (kind_r)
          KIND_CHAR:  state_nxt = ST_ADDR;
          KIND_CLEAR: state_nxt = ST_SM1;
          KIND_READ:  state_nxt = rd_in_range ? ST_ADDR : ST_FIN;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_ADDR: begin
        mac_a = (kind_r == KIND_READ) ? EROW_W'(py_r) : EROW_W'(cursor_row_r);
        mac_c = (kind_r == KIND_READ) ? ECOL_W'(px_r) : ECOL_W'(cursor_col_r);
        state_nxt = (kind_r == KIND_READ) ? ST_RDI : ST_WR;
      end
      ST_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = mac_res[AW-1:0];
        ram_wdata    = blank_cell;
        ram_wdata.ch = is_nl ? BLANK_CODE : char_r;
        if (scroll_hit) begin
          state_nxt = ST_SM1;
        end else if (is_nl && !wrap) begin
          state_nxt = ST_ADDR;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_RDI: begin
        ram_raddr = mac_res[AW-1:0];
        state_nxt = ST_RDD;
      end
      ST_RDD: begin
        ram_we          = 1'b1;
        ram_waddr       = addr_r;
        ram_wdata       = ram_rdata;
        ram_wdata.dirty = 1'b0;
        state_nxt       = ST_FIN;
      end
      ST_SM1: begin
        mac_a     = rows_m1;
        state_nxt = ST_SM2;
      end
      ST_SM2: begin
        mac_a     = rows_m1;
        mac_c     = eff_cols;
        state_nxt = ST_SPRIME;
      end
      ST_SPRIME: begin
        ram_raddr = src_first[AW-1:0];
        state_nxt = ST_SMOVE;
      end
      ST_SMOVE: begin
        ram_we    = 1'b1;
        ram_raddr = src_next[AW-1:0];
        if (i_r < lim_r) begin
          ram_wdata       = ram_rdata;
          ram_wdata.dirty = 1'b1;
        end
        if (move_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: sequencer, configuration, cursor, blink, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      i_r          <= '0;
      cols_used_r  <= COLS_RST;
      rows_used_r  <= ROWS_RST;
      fore_r       <= FORE_RST;
      back_r       <= BACK_RST;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      blink_cnt_r  <= BLINK_W'(BLINK_TICKS);
      blink_on_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      case (state_r)
        ST_INIT:   i_r <= i_r + CNT_W'(1);
        ST_SPRIME: i_r <= '0;
        ST_SMOVE:  i_r <= i_r + CNT_W'(1);
        ST_DISP: begin
          case (kind_r)
            KIND_CHAR: blink_cnt_r <= BLINK_W'(BLINK_TICKS);
            KIND_BLINK: begin
              if (blink_dec == '0) begin
                blink_on_r  <= !blink_on_r;
                blink_cnt_r <= BLINK_W'(BLINK_TICKS);
              end else begin
                blink_cnt_r <= blink_dec;
              end
            end
            KIND_SETCUR: begin
              cursor_col_r <= (ECOL_W'(px_r) >= eff_cols) ? last_col : px_r;
              cursor_row_r <= (EROW_W'(py_r) >= eff_rows) ? last_row : py_r;
            end
            default: ;
          endcase
        end
        ST_WR: begin
          if (wrap) begin
            cursor_col_r <= '0;
            cursor_row_r <= scroll_hit ? last_row : ROW_W'(row_inc);
          end else begin
            cursor_col_r <= COL_W'(col_inc);
          end
        end
        default: ;
      endcase

      if (state_r == ST_FIN && fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // A resize pulls the cursor back into the new used area.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: begin
            cols_used_r <= cfg_data;
            if (ECOL_W'(cursor_col_r) >= new_cols) begin
              cursor_col_r <= COL_W'(new_cols - ECOL_W'(1));
            end
          end
          CFG_ROWS: begin
            rows_used_r <= cfg_data;
            if (EROW_W'(cursor_row_r) >= new_rows) begin
              cursor_row_r <= ROW_W'(new_rows - EROW_W'(1));
            end
          end
          CFG_FORE: fore_r <= cfg_data[CLR_W-1:0];
          CFG_BACK: back_r <= cfg_data[CLR_W-1:0];
        endcase
      end
    end
  end

  // Payload and working registers; none need a reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_tuser;
      char_r    <= in_tdata[7:0];
      px_r      <= in_tdata[14:8];
      py_r      <= in_tdata[20:15];
      redraw_r  <= 1'b0;
      sc_r      <= 1'b0;
      rd_cell_r <= '0;
    end
    case (state_r)
      ST_DISP: begin
        clear_r <= (kind_r == KIND_CLEAR);
        if (kind_r == KIND_CHAR || kind_r == KIND_CLEAR) begin
          redraw_r <= 1'b1;
        end
        if (kind_r == KIND_BLINK && blink_dec == '0) begin
          redraw_r <= 1'b1;
        end
      end
      ST_WR: begin
        if (scroll_hit) begin
          sc_r <= 1'b1;
        end
      end
      ST_RDI:    addr_r    <= mac_res[AW-1:0];
      ST_RDD:    rd_cell_r <= ram_rdata;
      ST_SM2:    lim_r     <= clear_r ? '0 : mac_res;
      ST_SPRIME: tot_r     <= mac_res;
      ST_FIN: begin
        if (fin_load) begin
          out_data_r <= {7'd0, rd_cell_r.dirty, rd_cell_r.back, rd_cell_r.fore,
                         rd_cell_r.ch, sc_r, redraw_r, blink_on_r,
                         cursor_row_r, cursor_col_r};
        end
      end
      default: ;
    endcase
  end

  // Cell store.
  tccw_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiply-add: cell address row*cols+col, moved and total cell counts.
  tccw_mac #(
    .A_W (EROW_W),
    .B_W (ECOL_W),
    .C_W (ECOL_W),
    .R_W (CNT_W)
  ) u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (eff_cols),
    .c   (mac_c),
    .res (mac_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The cursor always stays inside the used area.
  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (ECOL_W'(cursor_col_r) < eff_cols) && (EROW_W'(cursor_row_r) < eff_rows))
    else $error("cursor outside the used area");

  // The blink counter reloads before it can reach zero.
  a_blink_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    blink_cnt_r != '0)
    else $error("blink counter reached zero");

  // The sweep stays inside the used area and moves no more cells than it has.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SMOVE) |-> ((i_r < tot_r) && (lim_r < tot_r)))
    else $error("sweep index beyond the used area");

  // A finished transaction waits while an untaken result holds the output.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_tready) |=> (state_r == ST_FIN))
    else $error("result register overwritten");

endmodule
